// ===== sv/mle_pkg.sv =====
`timescale 1ns / 1ps
package mle_pkg;

  localparam logic [2:0] OP_NOTE_ON  = 3'd0;
  localparam logic [2:0] OP_NOTE_OFF = 3'd1;
  localparam logic [2:0] OP_CC       = 3'd2;
  localparam logic [2:0] OP_CLOCK    = 3'd3;
  localparam logic [2:0] OP_START    = 3'd4;
  localparam logic [2:0] OP_STOP     = 3'd5;
  localparam logic [2:0] OP_TICK     = 3'd6;
  localparam logic [2:0] OP_READ     = 3'd7;

  localparam logic [2:0] REG_DECAY     = 3'd0;
  localparam logic [2:0] REG_CHASE     = 3'd1;
  localparam logic [2:0] REG_LPEAK     = 3'd2;
  localparam logic [2:0] REG_DIV       = 3'd3;
  localparam logic [2:0] REG_THRESH    = 3'd4;
  localparam logic [2:0] REG_SW_CH     = 3'd5;
  localparam logic [2:0] REG_BAR_CH    = 3'd6;
  localparam logic [2:0] REG_BAR_CTRL  = 3'd7;

  localparam logic [1:0] MODE_CHASE  = 2'd0;
  localparam logic [1:0] MODE_LEVEL  = 2'd1;
  localparam logic [1:0] MODE_BAR    = 2'd2;
  localparam logic [1:0] MODE_MIRROR = 2'd3;

  typedef struct packed {
    logic [2:0] operation;
    logic [4:0] midi_channel;
    logic [6:0] key;
    logic [6:0] amount;
    logic [5:0] pixel_index;
  } req_t;

  typedef struct packed {
    logic       show;
    logic [1:0] note_on_pulses;
    logic [1:0] note_off_pulses;
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
    logic [7:0] pixel_level;
    logic [1:0] effect;
  } res_t;

  // one decay step: neighbor overtake or saturating subtract
  function automatic logic [7:0] decay_val(input logic [7:0] cur, input logic [7:0] prev,
                                           input logic has_prev, input logic [7:0] step);
    logic [7:0] r;
    if (has_prev && cur < prev) r = prev;
    else if (cur > step) r = cur - step;
    else r = 8'd0;
    return r;
  endfunction

endpackage

// ===== sv/midi_led_effect_engine.sv =====
`timescale 1ns / 1ps
// Accept to done: start/stop and requests that touch no buffer go to S_DONE;
// note and clock pass S_RD, read S_RD then S_READ2; a bar graph walks each
// pixel; a tick passes S_RD, then walks the red (chase) or level store. busy
// drops in the done cycle, so the next request can be taken there. The
// receiver cannot stall. Reset (rst, synchronous): registers to defaults, then
// a clearing pass zeroes the pixel and level buffers while busy stays high.
module midi_led_effect_engine #(
  parameter int PIXELS = 60
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  mle_pkg::req_t req,
  output logic          done,
  output mle_pkg::res_t res,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [15:0]   cfg_data
);
  import mle_pkg::*;

  localparam int HALF = PIXELS / 2;
  localparam int AW = $clog2(PIXELS);
  localparam int LW = (HALF > 1) ? $clog2(HALF) : 1;

  // configuration
  logic [7:0]  decay_step, chase_peak, level_peak, clock_division;
  logic [15:0] level_tick_threshold;
  logic [4:0]  switch_channel, bar_channel;
  logic [6:0]  bar_controller;

  always_ff @(posedge clk) begin
    if (rst) begin
      decay_step <= 8'd3; chase_peak <= 8'd220; level_peak <= 8'd255;
      clock_division <= 8'd24; level_tick_threshold <= 16'd1000;
      switch_channel <= 5'd2; bar_channel <= 5'd3; bar_controller <= 7'd2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DECAY:    decay_step <= cfg_data[7:0];
        REG_CHASE:    chase_peak <= cfg_data[7:0];
        REG_LPEAK:    level_peak <= cfg_data[7:0];
        REG_DIV:      clock_division <= cfg_data[7:0];
        REG_THRESH:   level_tick_threshold <= cfg_data;
        REG_SW_CH:    switch_channel <= cfg_data[4:0];
        REG_BAR_CH:   bar_channel <= cfg_data[4:0];
        REG_BAR_CTRL: bar_controller <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  logic [7:0] div_limit;
  assign div_limit = (clock_division == 8'd0) ? 8'd0 : clock_division - 8'd1;

  // sequencer states
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;  // memory read issued
  localparam logic [2:0] S_WALK  = 3'd3;  // per-entry walk
  localparam logic [2:0] S_DONE  = 3'd4;
  localparam logic [2:0] S_READ2 = 3'd5;  // pixel read issued, data out with done

  logic [2:0]  state;
  req_t        cur;
  logic [AW:0] idx;       // walk index, counts down
  logic        walk_lvl;  // walking level store rather than red
  logic [7:0]  prev_val;  // value of entry idx (carried from q)
  logic        show_r;
  logic [1:0]  mode;
  logic [7:0]  clock_count;
  logic [15:0] tick_count;
  logic        running;
  logic [1:0]  pon, poff;

  // memories: red, green, blue, level
  logic [7:0] red_m [PIXELS];
  logic [7:0] grn_m [PIXELS];
  logic [7:0] blu_m [PIXELS];
  logic [7:0] lvl_m [HALF];

  logic [AW-1:0] r_addr;
  logic [LW-1:0] l_addr;
  logic [7:0]    r_q, g_q, b_q, l_q;
  logic          r_we, g_we, b_we, l_we;
  logic [AW-1:0] w_addr;
  logic [LW-1:0] lw_addr;
  logic [7:0]    r_wd, g_wd, b_wd, l_wd;

  always_ff @(posedge clk) begin
    if (r_we) red_m[w_addr] <= r_wd;
    if (g_we) grn_m[w_addr] <= g_wd;
    if (b_we) blu_m[w_addr] <= b_wd;
    if (l_we) lvl_m[lw_addr] <= l_wd;
    r_q <= red_m[r_addr];
    g_q <= grn_m[r_addr];
    b_q <= blu_m[r_addr];
    l_q <= lvl_m[l_addr];
  end

  // mirrored level address for a read
  logic [6:0] pidx;
  logic       lvl_ok;
  logic [LW-1:0] lvl_rd;
  always_comb begin
    pidx = {1'b0, cur.pixel_index};
    lvl_ok = 1'b0;
    lvl_rd = '0;
    if (pidx < 7'(HALF)) begin
      lvl_ok = 1'b1; lvl_rd = LW'(7'(HALF - 1) - pidx);
    end else if (pidx < 7'(2 * HALF)) begin
      lvl_ok = 1'b1; lvl_rd = LW'(pidx - 7'(HALF));
    end
  end

  // walk: current entry value comes from q (address idx), prev from q too
  // alternating is avoided by reading idx-1 each cycle and carrying.
  logic [7:0] walk_cur, walk_q;
  assign walk_q = walk_lvl ? l_q : r_q;

  // bar graph values
  logic [6:0] bar_v;
  assign bar_v = ({1'b0, cur.amount[6:1]} > 7'(PIXELS)) ? 7'(PIXELS)
                                                         : {1'b0, cur.amount[6:1]};
  logic is_bar_ch;
  assign is_bar_ch = (cur.midi_channel == bar_channel);

  // mirror pixel
  logic       mir_ok;
  logic [6:0] mir_p;
  assign mir_p = cur.key - 7'd32;
  assign mir_ok = (cur.key > 7'd32) && (cur.key < 7'd92) && (mir_p < 7'(PIXELS));
  logic [1:0] pulse_n;
  assign pulse_n = (cur.key == 7'd48 || cur.key == 7'd52 || cur.key == 7'd55) ? 2'd1 : 2'd2;

  logic [7:0] cc_next;
  assign cc_next = clock_count + 8'd1;
  logic [15:0] tc_next;
  assign tc_next = (tick_count != 16'hFFFF) ? tick_count + 16'd1 : tick_count;

  logic [AW:0] idx_m1;
  assign idx_m1 = idx - (AW+1)'(1);

  // single-entry writes for note and clock requests, done in S_RD
  // (these share the write port; walks never overlap them)
  logic       side_we;
  logic       side_red;
  assign side_red = (cur.operation == OP_CLOCK) && running && !mode[1] &&
                    (cc_next > div_limit);
  assign side_we = (state == S_RD) &&
                   (((cur.operation == OP_NOTE_ON && cur.midi_channel != switch_channel) ||
                     cur.operation == OP_NOTE_OFF) && mode == MODE_MIRROR && mir_ok);

  always_comb begin
    r_addr = cur.pixel_index[AW-1:0];
    l_addr = lvl_rd;
    r_we = 1'b0; g_we = 1'b0; b_we = 1'b0; l_we = 1'b0;
    w_addr = idx[AW-1:0]; lw_addr = idx[LW-1:0];
    r_wd = '0; g_wd = '0; b_wd = '0; l_wd = '0;
    walk_cur = prev_val;
    unique case (state)
      S_CLEAR: begin
        r_we = 1'b1; g_we = 1'b1; b_we = 1'b1;
        l_we = (idx < (AW+1)'(HALF));
      end
      S_IDLE: begin
        // addresses for first walk read: top entry of each store
        r_addr = AW'(PIXELS - 1);
        l_addr = LW'(HALF - 1);
      end
      S_RD: begin
        // first entry is in q now; request idx-1
        r_addr = idx_m1[AW-1:0];
        l_addr = idx_m1[LW-1:0];
        if (side_we) begin
          r_we = 1'b1; g_we = 1'b1; b_we = 1'b1;
          w_addr = mir_p[AW-1:0];
          g_wd = (cur.operation == OP_NOTE_ON) ? 8'd255 : 8'd0;
          b_wd = (cur.operation == OP_NOTE_ON) ? 8'd255 : 8'd0;
        end
        if (side_red) begin
          if (mode == MODE_CHASE) begin
            r_we = 1'b1; w_addr = '0; r_wd = chase_peak;
          end else begin
            l_we = 1'b1; lw_addr = '0; l_wd = level_peak;
          end
        end
      end
      S_WALK: begin
        if (cur.operation == OP_TICK) begin
          // prev_val holds entry idx, walk_q holds entry idx-1
          walk_cur = decay_val(prev_val, walk_q, idx != '0, decay_step);
          r_we = !walk_lvl; l_we = walk_lvl;
          r_wd = walk_cur; l_wd = walk_cur;
          r_addr = (idx_m1 == '0) ? '0 : AW'(idx_m1 - (AW+1)'(1));
          l_addr = (idx_m1 == '0) ? '0 : LW'(idx_m1 - (AW+1)'(1));
        end else begin
          if (is_bar_ch) begin
            g_we = 1'b1; g_wd = (8'(idx) < {1'b0, bar_v}) ? 8'd255 : 8'd0;
          end else begin
            b_we = 1'b1;
            b_wd = (8'(idx) >= 8'(PIXELS) - {1'b0, bar_v}) ? 8'd255 : 8'd0;
          end
        end
      end
      default: ;
    endcase
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR; idx <= (AW+1)'(PIXELS - 1);
      mode <= MODE_CHASE; clock_count <= 8'd23; tick_count <= '0;
      running <= 1'b0; walk_lvl <= 1'b0; done <= 1'b0;
      cur <= '0; show_r <= 1'b0; pon <= '0; poff <= '0; prev_val <= '0;
    end else begin
      done <= (state == S_DONE) || (state == S_READ2);
      unique case (state)
        S_CLEAR: begin
          if (idx == '0) state <= S_IDLE;
          else idx <= idx_m1;
        end
        S_IDLE: begin
          if (start) begin
            cur <= req; pon <= '0; poff <= '0;
            unique case (req.operation)
              OP_NOTE_ON, OP_NOTE_OFF, OP_CLOCK, OP_READ: begin
                show_r <= 1'b0; state <= S_RD;
              end
              OP_CC: begin
                if (mode == MODE_BAR && req.key == bar_controller) begin
                  idx <= (AW+1)'(PIXELS - 1); state <= S_WALK; show_r <= 1'b1;
                end else begin
                  show_r <= 1'b0; state <= S_DONE;
                end
              end
              OP_START, OP_STOP: begin
                clock_count <= div_limit; tick_count <= '0;
                running <= (req.operation == OP_START);
                show_r <= 1'b0; state <= S_DONE;
              end
              OP_TICK: begin
                if (running && mode == MODE_CHASE) begin
                  walk_lvl <= 1'b0; idx <= (AW+1)'(PIXELS - 1);
                  show_r <= 1'b1; state <= S_RD;
                end else if (running && mode == MODE_LEVEL &&
                             tc_next > level_tick_threshold) begin
                  tick_count <= '0; walk_lvl <= 1'b1;
                  idx <= (AW+1)'(HALF - 1); show_r <= 1'b1; state <= S_RD;
                end else begin
                  if (running && mode == MODE_LEVEL) tick_count <= tc_next;
                  show_r <= 1'b0; state <= S_DONE;
                end
              end
              default: begin
                show_r <= 1'b0; state <= S_DONE;
              end
            endcase
          end
        end
        S_RD: begin
          unique case (cur.operation)
            OP_TICK: begin
              // first walk value: entry top arrives here
              prev_val <= walk_q;
              state <= S_WALK;
            end
            OP_READ: state <= S_READ2;
            OP_NOTE_ON: begin
              if (cur.midi_channel == switch_channel) mode <= mode + 2'd1;
              else if (mode == MODE_MIRROR) begin
                pon <= pulse_n; show_r <= 1'b1;
              end
              state <= S_DONE;
            end
            OP_NOTE_OFF: begin
              if (mode == MODE_MIRROR) begin
                poff <= pulse_n; show_r <= 1'b1;
              end
              state <= S_DONE;
            end
            default: begin // clock
              if (running && !mode[1]) begin
                if (cc_next > div_limit) begin
                  clock_count <= '0; show_r <= 1'b1;
                end else clock_count <= cc_next;
              end
              state <= S_DONE;
            end
          endcase
        end
        S_WALK: begin
          if (cur.operation == OP_TICK) prev_val <= walk_q;
          if (idx == '0) state <= S_DONE;
          else idx <= idx_m1;
        end
        default: state <= S_IDLE;  // S_DONE, S_READ2: result goes out next cycle
      endcase
    end
  end

  logic rd_ok;
  assign rd_ok = ({1'b0, cur.pixel_index} < 7'(PIXELS));

  always_comb begin
    res = '0;
    res.show = show_r;
    res.note_on_pulses = pon;
    res.note_off_pulses = poff;
    res.effect = mode;
    if (cur.operation == OP_READ && rd_ok) begin
      res.pixel_red = r_q; res.pixel_green = g_q; res.pixel_blue = b_q;
      res.pixel_level = lvl_ok ? l_q : 8'd0;
    end
  end

endmodule

// ===== test/mle_checker.sv =====
`timescale 1ns / 1ps
// Watches the request, config and result channels of the LED effect engine,
// keeps its own copy of the engine state and compares each result.
module mle_checker #(
  parameter int PIXELS = 60
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          busy,
  input  mle_pkg::req_t req,
  input  logic          done,
  input  mle_pkg::res_t res,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [15:0]   cfg_data,
  output int            errors,
  output int            pending,
  output int            results_seen
);
  import mle_pkg::*;

  localparam int HALF = PIXELS / 2;

  logic [7:0] red_buf [64];
  logic [7:0] grn_buf [64];
  logic [7:0] blu_buf [64];
  logic [7:0] lvl_buf [64];
  logic [1:0] mode;
  logic [7:0] clk_cnt;
  logic [15:0] tick_cnt;
  logic run_flag;

  logic [7:0] decay_amt, chase_lvl, level_lvl, division;
  logic [15:0] tick_thresh;
  logic [4:0] sw_chan, bar_chan;
  logic [6:0] bar_cc;

  res_t expected_q[$];

  assign pending = expected_q.size();

  function automatic logic [7:0] div_top();
    return (division == 8'd0) ? 8'd0 : division - 8'd1;
  endfunction

  function automatic logic [1:0] pulse_count(logic [6:0] pitch);
    return (pitch == 7'd48 || pitch == 7'd52 || pitch == 7'd55) ? 2'd1 : 2'd2;
  endfunction

  function automatic void fade_red();
    for (int i = PIXELS - 1; i >= 0; i--) begin
      if (i > 0 && red_buf[i] < red_buf[i-1]) red_buf[i] = red_buf[i-1];
      else if (red_buf[i] > decay_amt) red_buf[i] = red_buf[i] - decay_amt;
      else red_buf[i] = 8'd0;
    end
  endfunction

  function automatic void fade_levels();
    for (int i = HALF - 1; i >= 0; i--) begin
      if (i > 0 && lvl_buf[i] < lvl_buf[i-1]) lvl_buf[i] = lvl_buf[i-1];
      else if (lvl_buf[i] > decay_amt) lvl_buf[i] = lvl_buf[i] - decay_amt;
      else lvl_buf[i] = 8'd0;
    end
  endfunction

  function automatic void set_mirror(logic [6:0] pitch, logic [7:0] gb);
    if (pitch > 7'd32 && pitch < 7'd92 && int'(pitch) - 32 < PIXELS) begin
      red_buf[pitch - 32] = 8'd0;
      grn_buf[pitch - 32] = gb;
      blu_buf[pitch - 32] = gb;
    end
  endfunction

  function automatic res_t predict_engine(req_t r);
    res_t o;
    int v;
    o = '0;
    case (r.operation)
      OP_NOTE_ON: begin
        if (r.midi_channel == sw_chan) mode = mode + 2'd1;
        else if (mode == MODE_MIRROR) begin
          set_mirror(r.key, 8'd255);
          o.note_on_pulses = pulse_count(r.key);
          o.show = 1'b1;
        end
      end
      OP_NOTE_OFF: begin
        if (mode == MODE_MIRROR) begin
          set_mirror(r.key, 8'd0);
          o.note_off_pulses = pulse_count(r.key);
          o.show = 1'b1;
        end
      end
      OP_CC: begin
        if (mode == MODE_BAR && r.key == bar_cc) begin
          v = int'(r.amount) / 2;
          if (v > PIXELS) v = PIXELS;
          for (int i = 0; i < PIXELS; i++) begin
            if (r.midi_channel == bar_chan) grn_buf[i] = (i < v) ? 8'd255 : 8'd0;
            else blu_buf[i] = (i >= PIXELS - v) ? 8'd255 : 8'd0;
          end
          o.show = 1'b1;
        end
      end
      OP_CLOCK: begin
        if (run_flag && mode < MODE_BAR) begin
          clk_cnt = clk_cnt + 8'd1;
          if (clk_cnt > div_top()) begin
            if (mode == MODE_CHASE) red_buf[0] = chase_lvl;
            else lvl_buf[0] = level_lvl;
            o.show = 1'b1;
            clk_cnt = 8'd0;
          end
        end
      end
      OP_START, OP_STOP: begin
        clk_cnt = div_top();
        tick_cnt = 16'd0;
        run_flag = (r.operation == OP_START);
      end
      OP_TICK: begin
        if (run_flag) begin
          if (mode == MODE_CHASE) begin
            fade_red();
            o.show = 1'b1;
          end else if (mode == MODE_LEVEL) begin
            if (tick_cnt != 16'hFFFF) tick_cnt = tick_cnt + 16'd1;
            if (tick_cnt > tick_thresh) begin
              fade_levels();
              o.show = 1'b1;
              tick_cnt = 16'd0;
            end
          end
        end
      end
      default: begin
        if (int'(r.pixel_index) < PIXELS) begin
          o.pixel_red = red_buf[r.pixel_index];
          o.pixel_green = grn_buf[r.pixel_index];
          o.pixel_blue = blu_buf[r.pixel_index];
          if (int'(r.pixel_index) < HALF) o.pixel_level = lvl_buf[HALF - 1 - r.pixel_index];
          else if (int'(r.pixel_index) < 2 * HALF) o.pixel_level = lvl_buf[r.pixel_index - HALF];
        end
      end
    endcase
    o.effect = mode;
    return o;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t mismatch on %s: got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      for (int i = 0; i < 64; i++) begin
        red_buf[i] = 0; grn_buf[i] = 0; blu_buf[i] = 0; lvl_buf[i] = 0;
      end
      mode = MODE_CHASE; tick_cnt = 0; run_flag = 0;
      decay_amt = 8'd3; chase_lvl = 8'd220; level_lvl = 8'd255; division = 8'd24;
      tick_thresh = 16'd1000; sw_chan = 5'd2; bar_chan = 5'd3; bar_cc = 7'd2;
      clk_cnt = div_top();
      expected_q.delete();
    end else begin
      // results first: a result can never belong to a request taken this edge
      if (done) begin
        results_seen++;
        if (expected_q.size() == 0) report_mismatch("unexpected result", 1, 0);
        else begin
          want = expected_q.pop_front();
          if (res.show !== want.show) report_mismatch("show", res.show, want.show);
          if (res.note_on_pulses !== want.note_on_pulses)
            report_mismatch("note_on_pulses", res.note_on_pulses, want.note_on_pulses);
          if (res.note_off_pulses !== want.note_off_pulses)
            report_mismatch("note_off_pulses", res.note_off_pulses, want.note_off_pulses);
          if (res.pixel_red !== want.pixel_red)
            report_mismatch("pixel_red", res.pixel_red, want.pixel_red);
          if (res.pixel_green !== want.pixel_green)
            report_mismatch("pixel_green", res.pixel_green, want.pixel_green);
          if (res.pixel_blue !== want.pixel_blue)
            report_mismatch("pixel_blue", res.pixel_blue, want.pixel_blue);
          if (res.pixel_level !== want.pixel_level)
            report_mismatch("pixel_level", res.pixel_level, want.pixel_level);
          if (res.effect !== want.effect) report_mismatch("effect", res.effect, want.effect);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_DECAY:    decay_amt = cfg_data[7:0];
          REG_CHASE:    chase_lvl = cfg_data[7:0];
          REG_LPEAK:    level_lvl = cfg_data[7:0];
          REG_DIV:      division = cfg_data[7:0];
          REG_THRESH:   tick_thresh = cfg_data;
          REG_SW_CH:    sw_chan = cfg_data[4:0];
          REG_BAR_CH:   bar_chan = cfg_data[4:0];
          default:      bar_cc = cfg_data[6:0];
        endcase
      end
      if (start && !busy) expected_q.push_back(predict_engine(req));
    end
  end

  initial begin
    errors = 0;
    results_seen = 0;
  end
endmodule

// ===== test/tb_midi_led_effect_engine.sv =====
`timescale 1ns / 1ps
// Stimulus and verdict for the LED effect engine. The checker beside the DUT
// does all prediction and comparison; this module only drives clock, reset,
// requests and config writes, then reads the checker's counts at the end.
module tb_midi_led_effect_engine;
  import mle_pkg::*;

  localparam int PIXELS = 60;
  localparam int RANDOM_REQUESTS = 450;
  localparam int SETTLE_CYCLES = PIXELS + 20;

  logic clk, rst, start, busy, done, cfg_we;
  req_t req;
  res_t res;
  logic [2:0] cfg_index;
  logic [15:0] cfg_data;
  int errors, pending, results_seen;
  int requests_sent;

  midi_led_effect_engine #(.PIXELS(PIXELS)) i_dut (
    .clk, .rst, .start, .busy, .req, .done, .res, .cfg_we, .cfg_index, .cfg_data
  );

  mle_checker #(.PIXELS(PIXELS)) i_checker (
    .clk, .rst, .start, .busy, .req, .done, .res, .cfg_we, .cfg_index, .cfg_data,
    .errors, .pending, .results_seen
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop: allow several times the slowest run, config pauses included.
  initial begin
    #2_000_000;
    $display("timeout with %0d results still owed", pending);
    $display("FAIL");
    $finish;
  end

  // Send one request: optional random idle gap, then hold start until taken.
  // start stays high straight into the next request when the gap is zero.
  task automatic send_request(req_t r, bit allow_gap = 1'b1);
    int gap;
    gap = allow_gap ? $urandom_range(0, 13) : 0;
    // keep some back-to-back stretches
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    requests_sent++;
  endtask

  task automatic go_idle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    // all results are in and busy is low; settle before the next phase
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one write, then the enable is dropped and held low before returning
  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic req_t make_req(logic [2:0] op, logic [4:0] ch, logic [6:0] key,
                                    logic [6:0] amt, logic [5:0] idx);
    req_t r;
    r.operation = op;
    r.midi_channel = ch;
    r.key = key;
    r.amount = amt;
    r.pixel_index = idx;
    return r;
  endfunction

  function automatic req_t random_req();
    req_t r;
    r = req_t'($bits(req_t)'($urandom));
    case ($urandom_range(0, 15))
      0, 1:      r.operation = OP_NOTE_ON;
      2:         r.operation = OP_NOTE_OFF;
      3, 4:      r.operation = OP_CC;
      5, 6, 7:   r.operation = OP_CLOCK;
      8:         r.operation = ($urandom_range(0, 3) == 0) ? OP_STOP : OP_START;
      9, 10, 11: r.operation = OP_TICK;
      default:   r.operation = OP_READ;
    endcase
    // mostly legal channels, keep the controller and pitches in useful ranges
    if ($urandom_range(0, 7) != 0) r.midi_channel = 5'($urandom_range(1, 16));
    if (r.operation == OP_CC && $urandom_range(0, 2) != 0) r.key = 7'd2;
    if ((r.operation == OP_NOTE_ON || r.operation == OP_NOTE_OFF) &&
        $urandom_range(0, 3) != 0) r.key = 7'($urandom_range(30, 95));
    // mode steps only now and then so every mode gets long runs
    if (r.operation == OP_NOTE_ON && r.midi_channel == 5'd2 && $urandom_range(0, 3) != 0)
      r.midi_channel = 5'd9;
    return r;
  endfunction

  task automatic random_phase(int count);
    for (int n = 0; n < count; n++) send_request(random_req());
  endtask

  initial begin
    start = 1'b0;
    req = '0;
    cfg_we = 1'b0;
    cfg_index = REG_DECAY;
    cfg_data = '0;
    requests_sent = 0;
    rst = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: every operation, read edges, mirror and pulse cases, bar extremes.
    send_request(make_req(OP_READ, 5'd1, 7'd0, 7'd0, 6'd0));
    send_request(make_req(OP_READ, 5'd1, 7'd0, 7'd0, 6'd63));
    send_request(make_req(OP_CLOCK, 5'd1, 7'd0, 7'd0, 6'd0));   // stopped: no effect
    send_request(make_req(OP_TICK, 5'd1, 7'd0, 7'd0, 6'd0));
    send_request(make_req(OP_START, 5'd1, 7'd0, 7'd0, 6'd0));
    repeat (24) send_request(make_req(OP_CLOCK, 5'd16, 7'd127, 7'd127, 6'd0), 1'b0);
    send_request(make_req(OP_TICK, 5'd1, 7'd0, 7'd0, 6'd0));
    send_request(make_req(OP_READ, 5'd1, 7'd0, 7'd0, 6'd1));
    send_request(make_req(OP_NOTE_ON, 5'd2, 7'd60, 7'd0, 6'd0)); // to level mode
    send_request(make_req(OP_NOTE_ON, 5'd2, 7'd60, 7'd0, 6'd0)); // to bar mode
    send_request(make_req(OP_CC, 5'd3, 7'd2, 7'd127, 6'd0));     // full green
    send_request(make_req(OP_CC, 5'd16, 7'd2, 7'd127, 6'd0));    // full blue
    send_request(make_req(OP_CC, 5'd3, 7'd2, 7'd0, 6'd0));
    send_request(make_req(OP_CC, 5'd1, 7'd2, 7'd1, 6'd0));
    send_request(make_req(OP_READ, 5'd1, 7'd0, 7'd0, 6'd59));
    send_request(make_req(OP_NOTE_ON, 5'd2, 7'd0, 7'd0, 6'd0)); // to mirror mode
    send_request(make_req(OP_NOTE_ON, 5'd1, 7'd48, 7'd0, 6'd0));
    send_request(make_req(OP_NOTE_ON, 5'd1, 7'd33, 7'd0, 6'd0));
    send_request(make_req(OP_NOTE_ON, 5'd1, 7'd91, 7'd0, 6'd0)); // last strip pixel
    send_request(make_req(OP_NOTE_ON, 5'd1, 7'd32, 7'd0, 6'd0));
    send_request(make_req(OP_NOTE_OFF, 5'd7, 7'd55, 7'd0, 6'd0));
    send_request(make_req(OP_NOTE_OFF, 5'd1, 7'd52, 7'd0, 6'd0));
    send_request(make_req(OP_READ, 5'd1, 7'd0, 7'd0, 6'd1));
    send_request(make_req(OP_STOP, 5'd1, 7'd0, 7'd0, 6'd0));
    send_request(make_req(OP_NOTE_ON, 5'd2, 7'd0, 7'd0, 6'd0)); // wrap to chase
    go_idle();

    random_phase(RANDOM_REQUESTS / 5);

    // Extremes: fast clock, heavy decay, odd channels, threshold zero.
    go_idle();
    write_reg(REG_DECAY, 16'd255);
    write_reg(REG_CHASE, 16'd255);
    write_reg(REG_LPEAK, 16'd0);
    write_reg(REG_DIV, 16'd1);
    write_reg(REG_THRESH, 16'd0);
    write_reg(REG_SW_CH, 16'd16);
    write_reg(REG_BAR_CH, 16'd1);
    write_reg(REG_BAR_CTRL, 16'd127);
    random_phase(RANDOM_REQUESTS / 5);

    // Slow decay, zero division, small threshold.
    go_idle();
    write_reg(REG_DECAY, 16'd0);
    write_reg(REG_CHASE, 16'd0);
    write_reg(REG_LPEAK, 16'd255);
    write_reg(REG_DIV, 16'd0);
    write_reg(REG_THRESH, 16'd2);
    write_reg(REG_SW_CH, 16'd1);
    write_reg(REG_BAR_CH, 16'd16);
    write_reg(REG_BAR_CTRL, 16'd0);
    random_phase(RANDOM_REQUESTS / 5);

    // Large division and maximum threshold.
    go_idle();
    write_reg(REG_DECAY, 16'd17);
    write_reg(REG_CHASE, 16'd200);
    write_reg(REG_LPEAK, 16'd128);
    write_reg(REG_DIV, 16'd255);
    write_reg(REG_THRESH, 16'hFFFF);
    write_reg(REG_SW_CH, 16'd2);
    write_reg(REG_BAR_CH, 16'd3);
    write_reg(REG_BAR_CTRL, 16'd2);
    random_phase(RANDOM_REQUESTS / 5);

    // Default channels with random decay, peaks, division and threshold.
    go_idle();
    write_reg(REG_DECAY, 16'($urandom_range(1, 40)));
    write_reg(REG_CHASE, 16'($urandom_range(0, 255)));
    write_reg(REG_LPEAK, 16'($urandom_range(0, 255)));
    write_reg(REG_DIV, 16'($urandom_range(2, 6)));
    write_reg(REG_THRESH, 16'($urandom_range(0, 5)));
    random_phase(RANDOM_REQUESTS / 5);

    go_idle();
    $display("sent %0d requests, checked %0d results over five register settings",
             requests_sent, results_seen);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
